// ----- rtl/mfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants for the motion JPEG frame splitter.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] MARK_SOI  = 8'hD8;
  localparam logic [7:0] MARK_EOI  = 8'hD9;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        lead_ff;
    logic        frame_start;
    logic        frame_end;
    logic        frame_abort;
    logic [15:0] frame_number;
  } out_t;

  // Word handed from the scanner to the result queue
  typedef struct packed {
    logic valid;
    out_t word;
  } emit_t;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_HUNT_FF = 7'b0000010,
    PH_BODY    = 7'b0000100,
    PH_BODY_FF = 7'b0001000,
    PH_LEN_HI  = 7'b0010000,
    PH_LEN_LO  = 7'b0100000,
    PH_SKIP    = 7'b1000000
  } phase_t;

endpackage

// ----- rtl/mfs_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_scanner
// Front end: walks the byte stream, tracks markers and segments, and
// classifies each accepted byte into at most one result word.
// ----------------------------------------------------------------------------
module mfs_scanner (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  logic          accept,
  input  mfs_pkg::in_t  item,
  output mfs_pkg::emit_t emit
);

  mfs_pkg::phase_t phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [15:0] frames_done, frames_done_next;
  logic [15:0] first_frame_number;

  logic [7:0]  b;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic        have, lead, start, fend, abort, open;
  logic [7:0]  ob;

  assign b        = item.data_byte;
  assign seg_len  = {length_high, b};
  assign skip_dec = skip_remaining - 16'd1;

  always_comb begin
    phase_next          = phase;
    length_high_next    = length_high;
    skip_remaining_next = skip_remaining;
    frames_done_next    = frames_done;
    have  = 1'b0;
    ob    = b;
    lead  = 1'b0;
    start = 1'b0;
    fend  = 1'b0;
    abort = 1'b0;
    open  = 1'b0;

    unique case (phase)
      mfs_pkg::PH_HUNT: begin
        if (b == mfs_pkg::BYTE_FF) phase_next = mfs_pkg::PH_HUNT_FF;
      end
      mfs_pkg::PH_HUNT_FF: begin
        if (b == mfs_pkg::MARK_SOI) begin
          have       = 1'b1;
          lead       = 1'b1;
          start      = 1'b1;
          phase_next = mfs_pkg::PH_BODY;
        end else if (b != mfs_pkg::BYTE_FF) begin
          phase_next = mfs_pkg::PH_HUNT;
        end
      end
      mfs_pkg::PH_BODY: begin
        if (b == mfs_pkg::BYTE_FF) phase_next = mfs_pkg::PH_BODY_FF;
        else have = 1'b1;
      end
      mfs_pkg::PH_BODY_FF: begin
        have = 1'b1;
        if (b == mfs_pkg::MARK_EOI) begin
          lead                = 1'b1;
          fend                = 1'b1;
          frames_done_next    = frames_done + 16'd1;
          phase_next          = mfs_pkg::PH_HUNT;
          length_high_next    = '0;
          skip_remaining_next = '0;
        end else if (b == mfs_pkg::BYTE_FF) begin
          // release the held FF as a plain byte, hold the new one
          ob = mfs_pkg::BYTE_FF;
        end else if (b == mfs_pkg::BYTE_ZERO) begin
          lead       = 1'b1;
          phase_next = mfs_pkg::PH_BODY;
        end else begin
          lead       = 1'b1;
          phase_next = mfs_pkg::PH_LEN_HI;
        end
      end
      mfs_pkg::PH_LEN_HI: begin
        have             = 1'b1;
        length_high_next = b;
        phase_next       = mfs_pkg::PH_LEN_LO;
      end
      mfs_pkg::PH_LEN_LO: begin
        have = 1'b1;
        // lengths below two skip nothing beyond the length bytes
        if (seg_len < 16'd2) skip_remaining_next = '0;
        else skip_remaining_next = seg_len - 16'd2;
        phase_next = (skip_remaining_next != '0) ? mfs_pkg::PH_SKIP : mfs_pkg::PH_BODY;
      end
      mfs_pkg::PH_SKIP: begin
        have                = 1'b1;
        skip_remaining_next = skip_dec;
        if (skip_dec == '0) phase_next = mfs_pkg::PH_BODY;
      end
      default: begin
        phase_next = mfs_pkg::PH_HUNT;
      end
    endcase

    if (item.end_of_stream) begin
      open = (phase_next != mfs_pkg::PH_HUNT) && (phase_next != mfs_pkg::PH_HUNT_FF);
      phase_next          = mfs_pkg::PH_HUNT;
      length_high_next    = '0;
      skip_remaining_next = '0;
      if (open) begin
        abort = 1'b1;
        if (!have) begin
          // flush a held FF as the last word
          ob   = mfs_pkg::BYTE_FF;
          lead = 1'b0;
        end
        have = 1'b1;
      end
    end
  end

  always_comb begin
    emit.valid             = accept && have;
    emit.word.frame_byte   = ob;
    emit.word.lead_ff      = lead;
    emit.word.frame_start  = start;
    emit.word.frame_end    = fend;
    emit.word.frame_abort  = abort;
    emit.word.frame_number = first_frame_number + frames_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= mfs_pkg::PH_HUNT;
      length_high        <= '0;
      skip_remaining     <= '0;
      frames_done        <= '0;
      first_frame_number <= '0;
    end else begin
      if (cfg_we) first_frame_number <= cfg_data;
      if (accept) begin
        phase          <= phase_next;
        length_high    <= length_high_next;
        skip_remaining <= skip_remaining_next;
        frames_done    <= frames_done_next;
      end
    end
  end

endmodule

// ----- rtl/mfs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfs_queue
// Back end: short result queue that decouples the scanner from the
// receiver and presents the oldest word on its read side.
// ----------------------------------------------------------------------------
module mfs_queue (
  input  logic           clk,
  input  logic           rst,
  input  mfs_pkg::emit_t emit,
  output logic           full,
  input  logic           rd_en,
  output mfs_pkg::out_t  rd_data,
  output logic           empty
);

  localparam int unsigned AW = mfs_pkg::QUEUE_AW;

  mfs_pkg::out_t mem [mfs_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign full    = (count == (AW+1)'(mfs_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = emit.valid && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= emit.word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= rd_ptr + AW'(1);
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/mjpeg_frame_splitter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjpeg_frame_splitter_core
// Splits a motion JPEG byte stream into numbered frames.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a byte is taken at a clock edge with
// push high and full low. end_of_stream marks the last byte of a stream.
// Results come out of a queue read port: while empty is low the oldest
// word sits on result, and pop at a clock edge takes it.
// Each byte is classified combinationally; a byte that yields a word writes
// it at the edge that takes the byte, so empty falls right after that edge
// and the word can be popped at the next one. One byte per
// clock is sustained as long as the receiver pops; marker and hunt bytes
// that yield nothing are still accepted like any other byte.
// A four-word queue sits between scanner and output; when the receiver
// stalls it fills and full rises, holding the sender until pop frees a
// slot. The user must write first_frame_number via cfg_we / cfg_data
// while the block is idle (not enforced); it takes effect on the next byte.
// Reset empties the queue, returns the scanner to hunting for a start
// marker, and clears the frame count and the base number.
// ----------------------------------------------------------------------------
module mjpeg_frame_splitter_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mfs_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output mfs_pkg::out_t result,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data
);

  mfs_pkg::emit_t emit;
  logic           accept;

  assign accept = push && !full;

  mfs_scanner u_scanner (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item),
    .emit     (emit)
  );

  mfs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .emit    (emit),
    .full    (full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

  a_no_full_and_empty : assert property (@(posedge clk) disable iff (rst)
    !(full && empty))
    else $error("queue reports full and empty together");

  a_end_not_abort : assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(result.frame_end && result.frame_abort))
    else $error("word flags both frame end and abort");

  a_start_marker : assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_start) |->
      (result.lead_ff && result.frame_byte == mfs_pkg::MARK_SOI))
    else $error("frame start word is not an FF D8 marker");

  a_end_marker : assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_end) |->
      (result.lead_ff && result.frame_byte == mfs_pkg::MARK_EOI))
    else $error("frame end word is not an FF D9 marker");

  a_word_lands : assert property (@(posedge clk) disable iff (rst)
    (accept && emit.valid) |=> !empty)
    else $error("classified word did not reach the queue");

endmodule

// ----- verif/mjpeg_frame_splitter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjpeg_frame_splitter_core_tb
// Self-checking bench for the motion JPEG frame splitter.
// ----------------------------------------------------------------------------
// Bytes go in through the push/full port and words come out through the
// empty/pop port. Each side idles at random. A scoreboard tracks the
// scanner state, the frame count and the base number, works out the word
// that each accepted byte yields and compares every popped word with it.
// A short directed run covers markers, stuffed bytes, FF runs, short
// segment lengths and the end-of-stream cases. Random frames follow, with
// segments, noise between frames and streams cut off mid-frame. The base
// number is rewritten between runs, its extremes included.
// ----------------------------------------------------------------------------
module mjpeg_frame_splitter_core_tb;

  class frame_scoreboard;
    mfs_pkg::out_t   expected_words[$];
    logic [15:0]     base_number;
    mfs_pkg::phase_t phase;
    logic [7:0]      len_high;
    logic [15:0]     skip_left;
    logic [15:0]     frames_done;
    int              errors;

    function new();
      base_number = '0;
      phase       = mfs_pkg::PH_HUNT;
      len_high    = '0;
      skip_left   = '0;
      frames_done = '0;
      errors      = 0;
    endfunction

    function void set_base(logic [15:0] value);
      base_number = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_byte(mfs_pkg::in_t it);
      logic [7:0]    b;
      logic [7:0]    ob;
      logic          have;
      logic          lead;
      logic          start;
      logic          fin;
      logic          abort_flag;
      logic          opened;
      logic [15:0]   seg_len;
      mfs_pkg::out_t word;
      b          = it.data_byte;
      ob         = '0;
      have       = 1'b0;
      lead       = 1'b0;
      start      = 1'b0;
      fin        = 1'b0;
      abort_flag = 1'b0;
      unique case (phase)
        mfs_pkg::PH_HUNT: begin
          if (b == mfs_pkg::BYTE_FF) phase = mfs_pkg::PH_HUNT_FF;
        end
        mfs_pkg::PH_HUNT_FF: begin
          if (b == mfs_pkg::MARK_SOI) begin
            have  = 1'b1;
            ob    = b;
            lead  = 1'b1;
            start = 1'b1;
            phase = mfs_pkg::PH_BODY;
          end else if (b != mfs_pkg::BYTE_FF) begin
            phase = mfs_pkg::PH_HUNT;
          end
        end
        mfs_pkg::PH_BODY: begin
          if (b == mfs_pkg::BYTE_FF) begin
            phase = mfs_pkg::PH_BODY_FF;
          end else begin
            have = 1'b1;
            ob   = b;
          end
        end
        mfs_pkg::PH_BODY_FF: begin
          have = 1'b1;
          ob   = b;
          if (b == mfs_pkg::MARK_EOI) begin
            lead      = 1'b1;
            fin       = 1'b1;
            phase     = mfs_pkg::PH_HUNT;
            len_high  = '0;
            skip_left = '0;
          end else if (b == mfs_pkg::BYTE_ZERO) begin
            lead  = 1'b1;
            phase = mfs_pkg::PH_BODY;
          end else if (b != mfs_pkg::BYTE_FF) begin
            lead  = 1'b1;
            phase = mfs_pkg::PH_LEN_HI;
          end
          // FF after FF: emit the held one as plain data and keep holding
        end
        mfs_pkg::PH_LEN_HI: begin
          have     = 1'b1;
          ob       = b;
          len_high = b;
          phase    = mfs_pkg::PH_LEN_LO;
        end
        mfs_pkg::PH_LEN_LO: begin
          have      = 1'b1;
          ob        = b;
          seg_len   = {len_high, b};
          // a length below two covers only the length bytes themselves
          skip_left = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
          phase     = (skip_left != 16'd0) ? mfs_pkg::PH_SKIP : mfs_pkg::PH_BODY;
        end
        mfs_pkg::PH_SKIP: begin
          have      = 1'b1;
          ob        = b;
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) phase = mfs_pkg::PH_BODY;
        end
        default: phase = mfs_pkg::PH_HUNT;
      endcase

      if (it.end_of_stream) begin
        opened    = (phase != mfs_pkg::PH_HUNT) && (phase != mfs_pkg::PH_HUNT_FF);
        phase     = mfs_pkg::PH_HUNT;
        len_high  = '0;
        skip_left = '0;
        if (opened) begin
          // a held FF at the cut is flushed as a bare byte
          if (!have) begin
            ob   = mfs_pkg::BYTE_FF;
            lead = 1'b0;
          end
          have       = 1'b1;
          abort_flag = 1'b1;
        end
      end

      if (have) begin
        word.frame_byte   = ob;
        word.lead_ff      = lead;
        word.frame_start  = start;
        word.frame_end    = fin;
        word.frame_abort  = abort_flag;
        word.frame_number = base_number + frames_done;
        expected_words.push_back(word);
      end
      if (fin) frames_done = frames_done + 16'd1;
    endfunction

    function void report(string what, mfs_pkg::out_t want, mfs_pkg::out_t got);
      errors++;
      if (errors <= 10) begin
        $display("%0t %s: expected byte %h lead %b start %b end %b abort %b number %h,",
                 $time, what, want.frame_byte, want.lead_ff, want.frame_start,
                 want.frame_end, want.frame_abort, want.frame_number);
        $display("    got byte %h lead %b start %b end %b abort %b number %h",
                 got.frame_byte, got.lead_ff, got.frame_start,
                 got.frame_end, got.frame_abort, got.frame_number);
      end
    endfunction

    function void check_word(mfs_pkg::out_t got);
      mfs_pkg::out_t want;
      if (expected_words.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        want = expected_words.pop_front();
        if (got.frame_byte !== want.frame_byte || got.lead_ff !== want.lead_ff ||
            got.frame_start !== want.frame_start || got.frame_end !== want.frame_end ||
            got.frame_abort !== want.frame_abort ||
            got.frame_number !== want.frame_number)
          report("word mismatch", want, got);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          push;
  logic          full;
  mfs_pkg::in_t  item;
  logic          empty;
  logic          pop;
  mfs_pkg::out_t result;
  logic          cfg_we;
  logic [15:0]   cfg_data;

  frame_scoreboard sb;
  mfs_pkg::in_t    byte_q[$];
  int              idle_pct;

  mjpeg_frame_splitter_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: take a word whenever pop meets a non-empty queue
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_word(result);
      pop <= ($urandom_range(99) < idle_pct) ? 1'b0 : 1'b1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic eos = 1'b0);
    mfs_pkg::in_t it;
    it.data_byte     = b;
    it.end_of_stream = eos;
    byte_q.push_back(it);
  endtask

  // Cut the stream on the byte just queued
  task automatic cut_stream();
    mfs_pkg::in_t it;
    it = byte_q.pop_back();
    it.end_of_stream = 1'b1;
    byte_q.push_back(it);
  endtask

  task automatic gen_frame();
    int          kind;
    int          seg_len;
    logic [7:0]  marker;
    repeat ($urandom_range(4)) put_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
    repeat ($urandom_range(2)) put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_SOI);
    repeat ($urandom_range(8, 2)) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        put_byte(8'($urandom_range(254)));
      end else if (kind < 60) begin
        put_byte(mfs_pkg::BYTE_FF);
        put_byte(mfs_pkg::BYTE_ZERO);
      end else if (kind < 68) begin
        put_byte(mfs_pkg::BYTE_FF);
        put_byte(mfs_pkg::BYTE_FF);
        put_byte(mfs_pkg::BYTE_ZERO);
      end else begin
        do marker = 8'($urandom_range(254, 1)); while (marker == mfs_pkg::MARK_EOI);
        seg_len = ($urandom_range(24) == 0) ? $urandom_range(300, 256) : $urandom_range(12);
        put_byte(mfs_pkg::BYTE_FF);
        put_byte(marker);
        put_byte(seg_len[15:8]);
        put_byte(seg_len[7:0]);
        repeat ((seg_len >= 2) ? seg_len - 2 : 0) put_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(29) == 0) begin
        cut_stream();
        return;
      end
    end
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_EOI, $urandom_range(5) == 0);
  endtask

  task automatic gen_random(input int target);
    while (byte_q.size() < target) gen_frame();
  endtask

  task automatic send_bytes();
    while (byte_q.size() != 0) begin
      if ($urandom_range(99) < idle_pct) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        item <= byte_q[0];
      end
      @(posedge clk);
      if (push && !full) begin
        sb.note_byte(item);
        void'(byte_q.pop_front());
      end
    end
    push <= 1'b0;
  endtask

  // Wait out every expected word, then idle before the next run
  task automatic settle();
    int waited;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_base(value);
  endtask

  initial begin
    sb        = new();
    idle_pct  = 8;
    rst      <= 1'b1;
    push     <= 1'b0;
    item     <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hunt noise, FF run before the start, stuffed and plain FF, short
    // segment length, one skipped byte, then the end marker
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(8'h12);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_SOI);
    put_byte(8'h7F);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::BYTE_ZERO);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::BYTE_ZERO);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_SOI);
    put_byte(8'h00);
    put_byte(8'h01);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(8'hE0);
    put_byte(8'h00);
    put_byte(8'h03);
    put_byte(8'hAA);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_EOI);
    send_bytes();
    settle();

    // End-of-stream cases: while hunting, on a held FF, on the start
    // marker, and a minimal frame closing on the final byte
    write_base(16'hFFFF);
    put_byte(8'h55, 1'b1);
    put_byte(mfs_pkg::BYTE_FF, 1'b1);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_SOI);
    put_byte(mfs_pkg::BYTE_FF, 1'b1);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_SOI, 1'b1);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_SOI);
    put_byte(mfs_pkg::BYTE_FF);
    put_byte(mfs_pkg::MARK_EOI, 1'b1);
    send_bytes();
    settle();

    write_base(16'($urandom_range(65535)));
    idle_pct = 0;
    gen_random(125);
    send_bytes();
    settle();

    write_base(16'h0000);
    idle_pct = 8;
    gen_random(125);
    send_bytes();
    settle();

    write_base(16'($urandom_range(65535)));
    gen_random(125);
    send_bytes();
    settle();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
